// ----- hdl/ffi_pkg.sv -----
package ffi_pkg;

  localparam int unsigned DataW     = 32;
  localparam int unsigned MaxPoints = 32;
  localparam int unsigned IdxW      = $clog2(MaxPoints);
  localparam int unsigned CntW      = 6;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned AccW      = 51;
  localparam int unsigned ProdW     = 2 * DataW;
  localparam int unsigned InDataW   = 136;
  localparam int unsigned OutDataW  = 40;
  localparam int unsigned CfgIdxW   = 3;

  localparam logic CMD_EVAL  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic MODE_LINEAR = 1'b0;
  localparam logic MODE_TABLE  = 1'b1;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_FEW = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_MODE  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SPG   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_DG    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_OFS   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_COUNT = 3'd4;

  typedef struct packed {
    logic                    mode;
    logic signed [DataW-1:0] setpoint_gain;
    logic signed [DataW-1:0] disturbance_gain;
    logic signed [DataW-1:0] output_offset;
    logic [CntW-1:0]         point_count;
  } cfg_t;

  typedef struct packed {
    logic                    is_write;
    logic signed [DataW-1:0] setpoint;
    logic signed [DataW-1:0] disturbance;
    logic [IdxW-1:0]         point_index;
    logic signed [DataW-1:0] point_x;
    logic signed [DataW-1:0] point_y;
  } item_t;

endpackage

// ----- hdl/ffi_front.sv -----
module ffi_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        in_cmd_i,
  input  logic [ffi_pkg::InDataW-1:0] in_data_i,
  output logic                        q_valid_o,
  input  logic                        q_ready_i,
  output ffi_pkg::item_t              q_item_o
);
  import ffi_pkg::*;

  item_t      fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  item_t      item;
  logic       push, pop;

  // classify and unpack the request
  always_comb begin
    item.is_write    = (in_cmd_i == CMD_WRITE);
    item.setpoint    = in_data_i[31:0];
    item.disturbance = in_data_i[63:32];
    item.point_index = in_data_i[68:64];
    item.point_x     = in_data_i[100:69];
    item.point_y     = in_data_i[132:101];
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_valid_o && q_ready_i;
  assign q_item_o   = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count out of range");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !pop) |=> cnt_q == 2'd2)
    else $error("queue lost an entry");
  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd0 |-> wr_ptr_q == rd_ptr_q)
    else $error("queue pointers disagree");

endmodule

// ----- hdl/ffi_back.sv -----
module ffi_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ffi_pkg::cfg_t                cfg_i,
  input  logic                         q_valid_i,
  output logic                         q_ready_o,
  input  ffi_pkg::item_t               q_item_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [ffi_pkg::DataW-1:0]    out_value_o,
  output logic [1:0]                   out_status_o
);
  import ffi_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MULD = 4'd1;
  localparam logic [3:0] S_ACCD = 4'd2;
  localparam logic [3:0] S_MULS = 4'd3;
  localparam logic [3:0] S_ACCS = 4'd4;
  localparam logic [3:0] S_RD0  = 4'd5;
  localparam logic [3:0] S_RD1  = 4'd6;
  localparam logic [3:0] S_CHK  = 4'd7;
  localparam logic [3:0] S_SRCH = 4'd8;
  localparam logic [3:0] S_SCMP = 4'd9;
  localparam logic [3:0] S_DIVI = 4'd10;
  localparam logic [3:0] S_DIV  = 4'd11;
  localparam logic [3:0] S_MULF = 4'd12;
  localparam logic [3:0] S_ADDF = 4'd13;
  localparam logic [3:0] S_FIN  = 4'd14;

  localparam logic signed [AccW-1:0] MaxV = AccW'((64'sd1 <<< (DataW - 1)) - 64'sd1);
  localparam logic signed [AccW-1:0] MinV = -MaxV - AccW'(1);

  logic [3:0]              st_q, st_d;
  logic signed [DataW-1:0] mem_x [MaxPoints];
  logic signed [DataW-1:0] mem_y [MaxPoints];
  logic signed [DataW-1:0] rdx_q, rdy_q;
  logic [IdxW-1:0]         rd_addr;

  logic signed [DataW-1:0] sp_q, dv_q, xlo_q, ylo_q, xhi_q, yhi_q;
  logic [IdxW-1:0]         lo_q, hi_q, mid;
  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  acc_q;
  logic [1:0]              stat_q;
  logic [DataW:0]          rem_q, dx_q;
  logic [FracBits-1:0]     quo_q;
  logic [3:0]              dcnt_q;
  logic [CntW-1:0]         n_eff;
  logic [IdxW-1:0]         last;
  logic [DataW+1:0]        rem_sh;
  logic signed [DataW:0]   dy;
  logic signed [ProdW-FracBits-1:0] prod_sh;

  logic                    out_valid_q;
  logic [DataW-1:0]        out_value_q;
  logic [1:0]              out_status_q;
  logic                    out_free;

  assign n_eff   = (cfg_i.point_count > CntW'(MaxPoints)) ? CntW'(MaxPoints)
                                                          : cfg_i.point_count;
  assign last    = IdxW'(n_eff - CntW'(1));
  assign mid     = IdxW'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);
  assign rem_sh  = {rem_q, 1'b0};
  assign dy      = $signed({yhi_q[DataW-1], yhi_q}) - $signed({ylo_q[DataW-1], ylo_q});
  assign prod_sh = (ProdW-FracBits)'(prod_q >>> FracBits);
  assign out_free = !out_valid_q || out_ready_i;

  assign q_ready_o    = (st_q == S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign out_value_o  = out_value_q;
  assign out_status_o = out_status_q;

  always_comb begin
    unique case (st_q)
      S_RD0:   rd_addr = '0;
      S_RD1:   rd_addr = last;
      default: rd_addr = mid;
    endcase
  end

  // table memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (st_q == S_IDLE && q_valid_i && q_item_i.is_write) begin
      mem_x[q_item_i.point_index] <= q_item_i.point_x;
      mem_y[q_item_i.point_index] <= q_item_i.point_y;
    end
    rdx_q <= mem_x[rd_addr];
    rdy_q <= mem_y[rd_addr];
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_IDLE: if (q_valid_i && !q_item_i.is_write) st_d = S_MULD;
      S_MULD: st_d = S_ACCD;
      S_ACCD: begin
        priority if (cfg_i.mode == MODE_LINEAR) st_d = S_MULS;
        else if (n_eff < CntW'(2))             st_d = S_FIN;
        else                                    st_d = S_RD0;
      end
      S_MULS: st_d = S_ACCS;
      S_ACCS: st_d = S_FIN;
      S_RD0:  st_d = S_RD1;
      S_RD1:  st_d = S_CHK;
      S_CHK: begin
        priority if (sp_q <= xlo_q || sp_q >= rdx_q) st_d = S_FIN;
        else if (last > IdxW'(1))                    st_d = S_SRCH;
        else                                         st_d = S_DIVI;
      end
      S_SRCH: st_d = S_SCMP;
      S_SCMP: begin
        if (sp_q < rdx_q) st_d = (mid - lo_q > IdxW'(1)) ? S_SRCH : S_DIVI;
        else              st_d = (hi_q - mid > IdxW'(1)) ? S_SRCH : S_DIVI;
      end
      S_DIVI: st_d = (xhi_q > xlo_q) ? S_DIV : S_FIN;
      S_DIV:  if (dcnt_q == 4'd15) st_d = S_MULF;
      S_MULF: st_d = S_ADDF;
      S_ADDF: st_d = S_FIN;
      S_FIN:  if (out_free) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      S_IDLE: begin
        sp_q   <= q_item_i.setpoint;
        dv_q   <= q_item_i.disturbance;
        stat_q <= ST_OK;
      end
      S_MULD: prod_q <= cfg_i.disturbance_gain * dv_q;
      S_ACCD: begin
        acc_q <= AccW'(cfg_i.output_offset) + AccW'(prod_sh);
        if (cfg_i.mode == MODE_TABLE && n_eff < CntW'(2)) stat_q <= ST_FEW;
      end
      S_MULS: prod_q <= cfg_i.setpoint_gain * sp_q;
      S_ACCS: acc_q  <= acc_q + AccW'(prod_sh);
      S_RD1: begin
        xlo_q <= rdx_q;
        ylo_q <= rdy_q;
      end
      S_CHK: begin
        xhi_q <= rdx_q;
        yhi_q <= rdy_q;
        lo_q  <= '0;
        hi_q  <= last;
        priority if (sp_q <= xlo_q) acc_q <= acc_q + AccW'(ylo_q);
        else if (sp_q >= rdx_q)     acc_q <= acc_q + AccW'(rdy_q);
        else                        acc_q <= acc_q;
      end
      S_SCMP: begin
        if (sp_q < rdx_q) begin
          hi_q  <= mid;
          xhi_q <= rdx_q;
          yhi_q <= rdy_q;
        end else begin
          lo_q  <= mid;
          xlo_q <= rdx_q;
          ylo_q <= rdy_q;
        end
      end
      S_DIVI: begin
        rem_q  <= (DataW+1)'({sp_q[DataW-1], sp_q} - {xlo_q[DataW-1], xlo_q});
        dx_q   <= (DataW+1)'({xhi_q[DataW-1], xhi_q} - {xlo_q[DataW-1], xlo_q});
        quo_q  <= '0;
        dcnt_q <= '0;
        if (!(xhi_q > xlo_q)) acc_q <= acc_q + AccW'(ylo_q);
      end
      S_DIV: begin
        // one quotient bit per cycle
        if (rem_sh >= {1'b0, dx_q}) begin
          rem_q <= (DataW+1)'(rem_sh - {1'b0, dx_q});
          quo_q <= {quo_q[FracBits-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh[DataW:0];
          quo_q <= {quo_q[FracBits-2:0], 1'b0};
        end
        dcnt_q <= dcnt_q + 4'd1;
      end
      S_MULF: prod_q <= ProdW'($signed({1'b0, quo_q})) * ProdW'(dy);
      S_ADDF: acc_q  <= acc_q + AccW'(ylo_q) + AccW'(prod_sh);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == S_FIN && out_free)  out_valid_q <= 1'b1;
      else if (out_ready_i)           out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == S_FIN && out_free) begin
      priority if (acc_q > MaxV) begin
        out_value_q  <= MaxV[DataW-1:0];
        out_status_q <= (stat_q == ST_OK) ? ST_SAT : stat_q;
      end else if (acc_q < MinV) begin
        out_value_q  <= MinV[DataW-1:0];
        out_status_q <= (stat_q == ST_OK) ? ST_SAT : stat_q;
      end else begin
        out_value_q  <= acc_q[DataW-1:0];
        out_status_q <= stat_q;
      end
    end
  end

  a_search_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_SRCH |-> (hi_q > lo_q) && (hi_q - lo_q > IdxW'(1)))
    else $error("search window collapsed");
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_DIV |-> rem_q < dx_q)
    else $error("divider remainder not below divisor");
  a_few_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_FIN && stat_q == ST_FEW) |-> cfg_i.mode == MODE_TABLE)
    else $error("too-few status outside table mode");

endmodule

// ----- hdl/feedforward_linear_or_table_interp_unit.sv -----
// Feedforward unit, signed Q16.16. A request with tuser high stores one breakpoint
// pair and gives no result; a request with tuser low returns offset + disturbance
// gain * disturbance plus either setpoint gain * setpoint or a piecewise-linear
// table lookup of the setpoint, saturated to 32 bits. Requests are handled one at a
// time by a sequencer behind a two-entry queue; a table evaluate makes two end
// point reads, one read and compare per binary-search step, a bit-per-cycle
// divider and one multiply. Configuration writes take effect at once
// and must only be issued while the unit is idle.
module feedforward_linear_or_table_interp_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // setpoint, disturbance, point_index, point_x, point_y, zero pad
  input  logic [ffi_pkg::InDataW-1:0]  s_axis_tdata,
  // cmd
  input  logic                         s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // feedforward_out, status, zero pad
  output logic [ffi_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic                         cfg_we_i,
  input  logic [ffi_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ffi_pkg::DataW-1:0]    cfg_data_i
);
  import ffi_pkg::*;

  cfg_t             cfg_q;
  logic             q_valid, q_ready;
  item_t            q_item;
  logic [DataW-1:0] out_value;
  logic [1:0]       out_status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MODE:  cfg_q.mode             <= cfg_data_i[0];
        REG_SPG:   cfg_q.setpoint_gain    <= cfg_data_i;
        REG_DG:    cfg_q.disturbance_gain <= cfg_data_i;
        REG_OFS:   cfg_q.output_offset    <= cfg_data_i;
        REG_COUNT: cfg_q.point_count      <= cfg_data_i[CntW-1:0];
        default: ;
      endcase
    end
  end

  ffi_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_cmd_i   (s_axis_tuser),
    .in_data_i  (s_axis_tdata),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_item_o   (q_item)
  );

  ffi_back u_back (
    .clk_i,
    .rst_ni,
    .cfg_i        (cfg_q),
    .q_valid_i    (q_valid),
    .q_ready_o    (q_ready),
    .q_item_i     (q_item),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_value_o  (out_value),
    .out_status_o (out_status)
  );

  assign m_axis_tdata = {6'd0, out_status, out_value};

endmodule
